// ===== design/lrucbp_pkg.sv =====
package lrucbp_pkg;

	localparam int DEF_ENTRIES   = 16;
	localparam int DEF_PIN_SLOTS = 16;
	localparam int DEF_KEY_BITS  = 32;

	localparam int KEY_W     = 32;
	localparam int BYTES_W   = 32;
	localparam int REG_W     = 32;
	localparam int CNT_W     = 5;
	localparam int TOTAL_W   = 36;
	localparam int PCNT_W    = 8;
	localparam int CFG_IDX_W = 1;
	localparam int S_DATA_W  = 72;
	localparam int M_DATA_W  = 56;

	localparam logic [PCNT_W-1:0] PIN_MAX = 8'd255;

	typedef enum logic [1:0] {
		CMD_ACCESS  = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_TRIM    = 2'd3
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES   = 1'd1;

endpackage

// ===== design/lrucbp_ram.sv =====
module lrucbp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/lru_cache_byte_budget_pinning_core.sv =====
// Flow: an accepted item runs a key and pin scan over SCAN = max(ENTRIES, PIN_SLOTS)
// table slots, then bookkeeping states (decide, insert, trim check, pin, done), plus a
// victim search over the same read pipeline for each eviction.
// Throughput: one item at a time; s_tready stays low until the result is issued, and a
// result waiting on m_tready holds the next item; the serial table scans through one read port set this.
// Reset: arst_n clears valid bits, pin counts, byte total, limits and handshakes.
module lru_cache_byte_budget_pinning_core import lrucbp_pkg::*; #(
	parameter int ENTRIES   = DEF_ENTRIES,
	parameter int PIN_SLOTS = DEF_PIN_SLOTS,
	parameter int KEY_BITS  = DEF_KEY_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,   // key[31:0], entry_bytes[63:32], pin[64]
	input  logic [1:0]           s_tuser,   // command[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata    // decode_miss[0], stored[1], pinned[2],
	                                        // evicted_count[7:3], entry_count[12:8],
	                                        // bytes_total[48:13], pin_overflow[49]
);

	localparam int EW     = $clog2(ENTRIES);
	localparam int PW     = (PIN_SLOTS > 1) ? $clog2(PIN_SLOTS) : 1;
	localparam int SCAN_N = (ENTRIES > PIN_SLOTS) ? ENTRIES : PIN_SLOTS;
	localparam int SW     = $clog2(SCAN_N + 1);
	localparam int CW     = $clog2(ENTRIES + 1);
	localparam int KB     = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_DECIDE, ST_FIND, ST_INSERT, ST_TRIMCHK, ST_PIN, ST_DONE
	} state_t;

	state_t state_q;

	logic [REG_W-1:0]   max_entries_q, max_bytes_q;
	logic               valid_q  [ENTRIES];
	logic               pinf_q   [ENTRIES];
	logic [EW-1:0]      rank_q   [ENTRIES];
	logic [PCNT_W-1:0]  pcnt_q   [PIN_SLOTS];
	logic [CW-1:0]      cnt_q;
	logic [TOTAL_W-1:0] tot_q;

	cmd_t               cmd_q;
	logic [KB-1:0]      k_q;
	logic [BYTES_W-1:0] sz_q;
	logic               want_q;

	logic [SW-1:0]      sc_q, idx_s1;
	logic               v_s1;

	logic               hit_q, free_q, ph_q, pfree_q, best_v_q, find_full_q, ins_live_q;
	logic [EW-1:0]      hit_e_q, free_e_q, best_e_q, best_rank_q, ins_slot_q;
	logic [PW-1:0]      ph_idx_q, pfree_idx_q;
	logic [PCNT_W-1:0]  ph_cnt_q;
	logic [BYTES_W-1:0] best_size_q;
	logic [CW-1:0]      ev_q;
	logic               dec_q, sto_q, pnd_q, ovf_q;
	logic               m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	logic [KB+BYTES_W-1:0] e_rdata;
	logic [KB-1:0]         p_rdata;
	logic                  e_we, p_we;
	logic [EW-1:0]         scan_e;
	logic [PW-1:0]         scan_p;
	logic [KB-1:0]         e_key;
	logic [BYTES_W-1:0]    e_size;
	logic                  in_ent, in_pin, scan_end;
	logic                  disabled, exceeded, fits, present;
	logic [EW-1:0]         pin_e;

	lrucbp_ram #(.WIDTH(KB + BYTES_W), .DEPTH(ENTRIES)) u_entry_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (ins_slot_q),
		.wdata ({sz_q, k_q}),
		.raddr (sc_q[EW-1:0]),
		.rdata (e_rdata)
	);

	lrucbp_ram #(.WIDTH(KB), .DEPTH(PIN_SLOTS)) u_pin_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (pfree_idx_q),
		.wdata (k_q),
		.raddr (sc_q[PW-1:0]),
		.rdata (p_rdata)
	);

	assign scan_e   = idx_s1[EW-1:0];
	assign scan_p   = idx_s1[PW-1:0];
	assign e_key    = e_rdata[KB-1:0];
	assign e_size   = e_rdata[KB+BYTES_W-1:KB];
	assign in_ent   = v_s1 && (idx_s1 < SW'(ENTRIES));
	assign in_pin   = v_s1 && (idx_s1 < SW'(PIN_SLOTS));
	assign scan_end = (sc_q == SW'(SCAN_N)) && !v_s1;

	assign disabled = (max_entries_q == '0) && (max_bytes_q == '0);
	assign exceeded = disabled
		|| ((max_entries_q != '0) && (REG_W'(cnt_q) > max_entries_q))
		|| ((max_bytes_q != '0) && (tot_q > TOTAL_W'(max_bytes_q)));
	assign fits     = !((max_bytes_q != '0) && (sz_q > max_bytes_q));
	assign present  = hit_q || ins_live_q;
	assign pin_e    = hit_q ? hit_e_q : ins_slot_q;

	assign e_we = (state_q == ST_INSERT);
	assign p_we = (state_q == ST_PIN) && want_q && present && !ph_q && pfree_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			max_entries_q <= '0;
			max_bytes_q   <= '0;
			cnt_q         <= '0;
			tot_q         <= '0;
			m_tvalid_q    <= 1'b0;
			v_s1          <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				pinf_q[i]  <= 1'b0;
			end
			for (int i = 0; i < PIN_SLOTS; i++) begin
				pcnt_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_ENTRIES: max_entries_q <= cfg_wdata;
					REG_MAX_BYTES:   max_bytes_q   <= cfg_wdata;
					default: ;
				endcase
			end
			// ST_DONE drives the valid flag itself
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end

			// read pipeline shared by the key scan and the victim search
			if (state_q == ST_SCAN || state_q == ST_FIND) begin
				v_s1   <= (sc_q != SW'(SCAN_N));
				idx_s1 <= sc_q;
				if (sc_q != SW'(SCAN_N)) begin
					sc_q <= sc_q + SW'(1);
				end
			end else begin
				v_s1 <= 1'b0;
				sc_q <= '0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q      <= cmd_t'(s_tuser);
						k_q        <= s_tdata[KB-1:0];
						sz_q       <= s_tdata[KEY_W+BYTES_W-1:KEY_W];
						want_q     <= s_tdata[KEY_W+BYTES_W];
						hit_q      <= 1'b0;
						free_q     <= 1'b0;
						ph_q       <= 1'b0;
						pfree_q    <= 1'b0;
						ins_live_q <= 1'b0;
						ev_q       <= '0;
						dec_q      <= 1'b0;
						sto_q      <= 1'b0;
						pnd_q      <= 1'b0;
						ovf_q      <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (in_ent) begin
						if (valid_q[scan_e] && e_key == k_q) begin
							hit_q   <= 1'b1;
							hit_e_q <= scan_e;
						end
						if (!valid_q[scan_e] && !free_q) begin
							free_q   <= 1'b1;
							free_e_q <= scan_e;
						end
					end
					if (in_pin) begin
						if (pcnt_q[scan_p] != '0 && p_rdata == k_q) begin
							ph_q     <= 1'b1;
							ph_idx_q <= scan_p;
							ph_cnt_q <= pcnt_q[scan_p];
						end
						if (pcnt_q[scan_p] == '0 && !pfree_q) begin
							pfree_q     <= 1'b1;
							pfree_idx_q <= scan_p;
						end
					end
					if (scan_end) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					best_v_q    <= 1'b0;
					find_full_q <= 1'b0;
					unique case (cmd_q)
						CMD_ACCESS: begin
							if (hit_q) begin
								for (int i = 0; i < ENTRIES; i++) begin
									if (valid_q[i] && rank_q[i] < rank_q[hit_e_q]) begin
										rank_q[i] <= rank_q[i] + EW'(1);
									end
								end
								rank_q[hit_e_q] <= '0;
								state_q <= ST_PIN;
							end else begin
								dec_q <= 1'b1;
								if (!disabled && fits) begin
									if (cnt_q == CW'(ENTRIES)) begin
										find_full_q <= 1'b1;
										state_q     <= ST_FIND;
									end else begin
										ins_slot_q <= free_e_q;
										state_q    <= ST_INSERT;
									end
								end else begin
									state_q <= ST_PIN;
								end
							end
						end
						CMD_RELEASE: begin
							if (ph_q) begin
								pcnt_q[ph_idx_q] <= ph_cnt_q - PCNT_W'(1);
								if (ph_cnt_q == PCNT_W'(1) && hit_q) begin
									pinf_q[hit_e_q] <= 1'b0;
								end
								state_q <= ST_TRIMCHK;
							end else begin
								state_q <= ST_DONE;
							end
						end
						CMD_CLEAR: begin
							for (int i = 0; i < ENTRIES; i++) begin
								valid_q[i] <= 1'b0;
							end
							cnt_q   <= '0;
							tot_q   <= '0;
							state_q <= ST_DONE;
						end
						CMD_TRIM: state_q <= ST_TRIMCHK;
						default: state_q <= ST_DONE;
					endcase
				end
				ST_FIND: begin
					// oldest unpinned entry: highest rank among valid, unpinned
					if (in_ent && valid_q[scan_e] && !pinf_q[scan_e]
							&& (!best_v_q || rank_q[scan_e] > best_rank_q)) begin
						best_v_q    <= 1'b1;
						best_e_q    <= scan_e;
						best_rank_q <= rank_q[scan_e];
						best_size_q <= e_size;
					end
					if (scan_end) begin
						if (best_v_q) begin
							for (int i = 0; i < ENTRIES; i++) begin
								if (valid_q[i] && rank_q[i] > best_rank_q) begin
									rank_q[i] <= rank_q[i] - EW'(1);
								end
							end
							valid_q[best_e_q] <= 1'b0;
							tot_q <= tot_q - TOTAL_W'(best_size_q);
							cnt_q <= cnt_q - CW'(1);
							ev_q  <= ev_q + CW'(1);
							if (ins_live_q && best_e_q == ins_slot_q) begin
								ins_live_q <= 1'b0;
							end
							if (find_full_q) begin
								ins_slot_q <= best_e_q;
								state_q    <= ST_INSERT;
							end else begin
								state_q <= ST_TRIMCHK;
							end
						end else begin
							state_q <= (cmd_q == CMD_ACCESS) ? ST_PIN : ST_DONE;
						end
						best_v_q    <= 1'b0;
						find_full_q <= 1'b0;
					end
				end
				ST_INSERT: begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (valid_q[i]) begin
							rank_q[i] <= rank_q[i] + EW'(1);
						end
					end
					rank_q[ins_slot_q]  <= '0;
					valid_q[ins_slot_q] <= 1'b1;
					pinf_q[ins_slot_q]  <= ph_q;
					tot_q      <= tot_q + TOTAL_W'(sz_q);
					cnt_q      <= cnt_q + CW'(1);
					ins_live_q <= 1'b1;
					state_q    <= ST_TRIMCHK;
				end
				ST_TRIMCHK: begin
					if (cnt_q != '0 && exceeded) begin
						state_q <= ST_FIND;
					end else begin
						state_q <= (cmd_q == CMD_ACCESS) ? ST_PIN : ST_DONE;
					end
				end
				ST_PIN: begin
					sto_q <= !hit_q && ins_live_q;
					if (want_q && present) begin
						if (ph_q) begin
							if (ph_cnt_q == PIN_MAX) begin
								ovf_q <= 1'b1;
							end else begin
								pcnt_q[ph_idx_q] <= ph_cnt_q + PCNT_W'(1);
								pinf_q[pin_e]    <= 1'b1;
								pnd_q            <= 1'b1;
							end
						end else if (pfree_q) begin
							pcnt_q[pfree_idx_q] <= PCNT_W'(1);
							pinf_q[pin_e]       <= 1'b1;
							pnd_q               <= 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= M_DATA_W'({ovf_q, tot_q, CNT_W'(cnt_q), CNT_W'(ev_q),
							pnd_q, sto_q, dec_q});
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/lrucbp_checker.sv =====
module lrucbp_checker import lrucbp_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	a_stored_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[1] && !m_tdata[0]))
		else $error("stored set on a hit");

	a_pin_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[2] && m_tdata[49]))
		else $error("pin taken and overflow together");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (ENTRIES < 32) |-> (32'(m_tdata[12:8]) <= 32'(ENTRIES)))
		else $error("entry count beyond table size");

endmodule

bind lru_cache_byte_budget_pinning_core lrucbp_checker #(.ENTRIES(ENTRIES)) u_lrucbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== bench/lru_cache_byte_budget_pinning_core_chk.sv =====
module lru_cache_byte_budget_pinning_core_chk import lrucbp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_wdata,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,
	input  logic [1:0]           s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_DATA_W-1:0]  m_tdata,
	output int                   fail_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = 16;
	localparam int NPIN  = 16;

	// highest field first, so the struct overlays m_tdata[49:0]
	typedef struct packed {
		logic               pin_overflow;
		logic [TOTAL_W-1:0] bytes_total;
		logic [CNT_W-1:0]   entry_count;
		logic [CNT_W-1:0]   evicted_count;
		logic               pinned;
		logic               stored;
		logic               decode_miss;
	} lookup_res_t;

	logic [KEY_W-1:0]   slot_key [NSLOT];
	logic [BYTES_W-1:0] slot_size [NSLOT];
	logic               slot_vld [NSLOT];
	int                 slot_age [NSLOT];
	logic [TOTAL_W-1:0] byte_sum;
	logic [KEY_W-1:0]   pkey [NPIN];
	logic [PCNT_W-1:0]  pcnt [NPIN];
	logic [REG_W-1:0]   lim_entries, lim_bytes;
	lookup_res_t        expected_q[$];

	function automatic int slot_of(logic [KEY_W-1:0] k);
		for (int i = 0; i < NSLOT; i++)
			if (slot_vld[i] && slot_key[i] == k) return i;
		return -1;
	endfunction

	function automatic int pin_of(logic [KEY_W-1:0] k);
		for (int i = 0; i < NPIN; i++)
			if (pcnt[i] != 0 && pkey[i] == k) return i;
		return -1;
	endfunction

	function automatic int n_valid();
		int n;
		n = 0;
		for (int i = 0; i < NSLOT; i++)
			if (slot_vld[i]) n++;
		return n;
	endfunction

	function automatic int lru_victim();
		int best;
		best = -1;
		for (int i = 0; i < NSLOT; i++) begin
			if (!slot_vld[i] || pin_of(slot_key[i]) >= 0) continue;
			if (best < 0 || slot_age[i] > slot_age[best]) best = i;
		end
		return best;
	endfunction

	function automatic void drop_slot(int e);
		for (int i = 0; i < NSLOT; i++)
			if (slot_vld[i] && slot_age[i] > slot_age[e]) slot_age[i]--;
		slot_vld[e] = 1'b0;
		byte_sum -= TOTAL_W'(slot_size[e]);
	endfunction

	function automatic bit cache_off();
		return lim_entries == 0 && lim_bytes == 0;
	endfunction

	function automatic bit over_limit();
		return cache_off() || (lim_entries != 0 && n_valid() > lim_entries) ||
			(lim_bytes != 0 && byte_sum > lim_bytes);
	endfunction

	function automatic int shrink();
		int n, e;
		n = 0;
		while (n_valid() > 0 && over_limit()) begin
			e = lru_victim();
			if (e < 0) break;
			drop_slot(e);
			n++;
		end
		return n;
	endfunction

	function automatic lookup_res_t lookup(cmd_t cmd, logic [KEY_W-1:0] k,
			logic [BYTES_W-1:0] sz, logic want);
		lookup_res_t r;
		int e, v, fr, s, ev;
		bit room;
		r = '0;
		ev = 0;
		case (cmd)
			CMD_ACCESS: begin
				e = slot_of(k);
				if (e >= 0) begin
					for (int i = 0; i < NSLOT; i++)
						if (slot_vld[i] && slot_age[i] < slot_age[e]) slot_age[i]++;
					slot_age[e] = 0;
				end else begin
					r.decode_miss = 1'b1;
					if (!cache_off() && !(lim_bytes != 0 && sz > lim_bytes)) begin
						room = 1;
						if (n_valid() >= NSLOT) begin
							v = lru_victim();
							if (v >= 0) begin
								drop_slot(v);
								ev++;
							end else room = 0;
						end
						if (room) begin
							fr = -1;
							for (int i = NSLOT - 1; i >= 0; i--)
								if (!slot_vld[i]) fr = i;
							if (fr >= 0) begin
								for (int i = 0; i < NSLOT; i++)
									if (slot_vld[i]) slot_age[i]++;
								slot_vld[fr] = 1'b1;
								slot_key[fr] = k;
								slot_size[fr] = sz;
								slot_age[fr] = 0;
								byte_sum += TOTAL_W'(sz);
								ev += shrink();
							end
						end
					end
					r.stored = slot_of(k) >= 0;
				end
				if (want && slot_of(k) >= 0) begin
					s = pin_of(k);
					if (s >= 0) begin
						if (pcnt[s] >= PIN_MAX) r.pin_overflow = 1'b1;
						else begin
							pcnt[s]++;
							r.pinned = 1'b1;
						end
					end else begin
						fr = -1;
						for (int i = NPIN - 1; i >= 0; i--)
							if (pcnt[i] == 0) fr = i;
						if (fr >= 0) begin
							pkey[fr] = k;
							pcnt[fr] = 1;
							r.pinned = 1'b1;
						end else r.pin_overflow = 1'b1;
					end
				end
			end
			CMD_RELEASE: begin
				s = pin_of(k);
				if (s >= 0) begin
					pcnt[s]--;
					ev += shrink();
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < NSLOT; i++) slot_vld[i] = 1'b0;
				byte_sum = '0;
			end
			default: ev += shrink();
		endcase
		r.evicted_count = ev[CNT_W-1:0];
		r.entry_count = CNT_W'(n_valid());
		r.bytes_total = byte_sum;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lookup_res_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < NSLOT; i++) slot_vld[i] = 1'b0;
			for (int i = 0; i < NPIN; i++) pcnt[i] = '0;
			byte_sum = '0;
			lim_entries = '0;
			lim_bytes = '0;
			fail_count = 0;
			expected_q.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MAX_ENTRIES) lim_entries = cfg_wdata;
				else lim_bytes = cfg_wdata;
			end
			if (s_tvalid && s_tready)
				expected_q = {expected_q, lookup(cmd_t'(s_tuser), s_tdata[31:0],
					s_tdata[63:32], s_tdata[64])};
			if (m_tvalid && m_tready) begin
				got = lookup_res_t'(m_tdata[49:0]);
				if (expected_q.size() == 0)
					report_mismatch("unexpected transfer", 64'(m_tdata), 64'(0));
				else begin
					want = expected_q.pop_front();
					if (got.decode_miss != want.decode_miss)
						report_mismatch("decode_miss", 64'(got.decode_miss),
							64'(want.decode_miss));
					if (got.stored != want.stored)
						report_mismatch("stored", 64'(got.stored), 64'(want.stored));
					if (got.pinned != want.pinned)
						report_mismatch("pinned", 64'(got.pinned), 64'(want.pinned));
					if (got.evicted_count != want.evicted_count)
						report_mismatch("evicted_count", 64'(got.evicted_count),
							64'(want.evicted_count));
					if (got.entry_count != want.entry_count)
						report_mismatch("entry_count", 64'(got.entry_count),
							64'(want.entry_count));
					if (got.bytes_total != want.bytes_total)
						report_mismatch("bytes_total", 64'(got.bytes_total),
							64'(want.bytes_total));
					if (got.pin_overflow != want.pin_overflow)
						report_mismatch("pin_overflow", 64'(got.pin_overflow),
							64'(want.pin_overflow));
				end
			end
			pending = expected_q.size();
		end
	end
endmodule

// ===== bench/lru_cache_byte_budget_pinning_core_tb.sv =====
module lru_cache_byte_budget_pinning_core_tb import lrucbp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;

	logic                 clk, arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_wdata;
	logic                 s_tvalid, s_tready;
	logic [S_DATA_W-1:0]  s_tdata;
	logic [1:0]           s_tuser;
	logic                 m_tvalid, m_tready;
	logic [M_DATA_W-1:0]  m_tdata;
	int                   fail_count, pending;
	int                   idle_cycles;
	int                   hold_cycles;
	int                   hold_done;
	logic [KEY_W-1:0]     key_pool [8];

	lru_cache_byte_budget_pinning_core u_top (.*);
	lru_cache_byte_budget_pinning_core_chk u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stall pattern, with a long hold-off when asked
	initial begin
		m_tready = 1'b0;
		hold_cycles = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready <= 1'b0;
			end else case ($urandom_range(0, 3))
				0: m_tready <= 1'b0;
				default: m_tready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) idle_cycles <= 0;
		else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("lru_cache_byte_budget_pinning_core: mismatch");
				$finish;
			end
		end
	end

	task automatic send(cmd_t cmd, logic [KEY_W-1:0] k, logic [BYTES_W-1:0] sz, logic p);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {7'd0, p, sz, k};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic gap();
		s_tvalid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	task automatic set_limits(logic [REG_W-1:0] ne, logic [REG_W-1:0] nb);
		drain();
		write_reg(REG_MAX_ENTRIES, ne);
		write_reg(REG_MAX_BYTES, nb);
		cfg_we <= 1'b0;
		send(CMD_TRIM, '0, '0, 1'b0);
	endtask

	task automatic random_item(int big);
		logic [KEY_W-1:0] k;
		logic [BYTES_W-1:0] sz;
		int r;
		k = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)] +
			$urandom_range(0, 20);
		sz = big ? $urandom() : $urandom_range(1, 400);
		r = $urandom_range(0, 99);
		if (r < 65) send(CMD_ACCESS, k, sz, $urandom_range(0, 2) == 0);
		else if (r < 88) send(CMD_RELEASE, k, sz, 1'($urandom_range(0, 1)));
		else if (r < 94) send(CMD_CLEAR, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
		else send(CMD_TRIM, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		hold_done = 0;
		for (int i = 0; i < 8; i++) key_pool[i] = $urandom() & ~32'h1f;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled cache, then limits at the extremes
		send(CMD_ACCESS, 32'h0, 32'h0, 1'b1);
		send(CMD_ACCESS, 32'hffffffff, 32'hffffffff, 1'b1);
		set_limits(32'hffffffff, 32'hffffffff);
		send(CMD_ACCESS, 32'hffffffff, 32'hffffffff, 1'b1);
		send(CMD_ACCESS, 32'hffffffff, 32'h5, 1'b1);
		send(CMD_ACCESS, 32'h0, 32'hffffffff, 1'b0);
		send(CMD_RELEASE, 32'hffffffff, 32'h0, 1'b0);
		send(CMD_RELEASE, 32'h1234, 32'h0, 1'b0);
		// fill past the physical table, each access asking for a pin
		for (int i = 0; i < 17; i++) send(CMD_ACCESS, i + 1, 32'd10, 1'b1);
		send(CMD_ACCESS, 32'd100, 32'd10, 1'b1);
		send(CMD_CLEAR, 32'h0, 32'h0, 1'b0);
		set_limits(32'd2, 32'd100);
		send(CMD_ACCESS, 32'd200, 32'd101, 1'b0);
		send(CMD_ACCESS, 32'd201, 32'd60, 1'b0);
		send(CMD_ACCESS, 32'd202, 32'd60, 1'b0);
		// saturate a pin count
		for (int i = 0; i < 256; i++) send(CMD_ACCESS, 32'd1, 32'd1, 1'b1);
		for (int i = 0; i < 260; i++) send(CMD_RELEASE, 32'd1, 32'd0, 1'b0);
		for (int i = 1; i <= 17; i++) send(CMD_RELEASE, i, 32'd0, 1'b0);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_limits(32'd4, 32'd0);
				1: set_limits(32'd0, 32'd900);
				2: set_limits(32'd6, 32'd1200);
				3: set_limits(32'd1, 32'd1);
				4: set_limits(32'hffffffff, 32'd0);
				default: set_limits(32'd0, 32'hffffffff);
			endcase
			for (int n = 0; n < 90;) begin
				for (int b = $urandom_range(1, 12); b > 0 && n < 90; b--) begin
					random_item(ph == 5 && $urandom_range(0, 3) == 0);
					n++;
				end
				if ($urandom_range(0, 2) != 0) gap();
				if (n >= 45 && ph == 2 && hold_done == 0) begin
					hold_cycles = 400;
					hold_done = 1;
				end
			end
		end
		drain();
		if (fail_count == 0)
			$display("lru_cache_byte_budget_pinning_core: match");
		else
			$display("lru_cache_byte_budget_pinning_core: mismatch");
		$finish;
	end
endmodule
